@@ sv/gbp_pkg.sv @@
// Shared types and constants for the gshare predictor with branch target buffer.
// Holds the table sizes, counter codes and the packed words of both channels.
// No dependencies.
package gbp_pkg;

  localparam int BTB_ENTRIES = 256;
  localparam int PHT_ENTRIES = 1024;
  localparam int BTB_IW      = $clog2(BTB_ENTRIES);
  localparam int PHT_IW      = $clog2(PHT_ENTRIES);

  // two-bit saturating counter codes
  localparam logic [1:0] CTR_SNT = 2'b00;
  localparam logic [1:0] CTR_WNT = 2'b01;
  localparam logic [1:0] CTR_WT  = 2'b10;
  localparam logic [1:0] CTR_ST  = 2'b11;

  localparam logic KIND_PREDICT = 1'b0;
  localparam logic KIND_RESOLVE = 1'b1;

  typedef struct packed {
    logic               kind;
    logic [31:0]        fetch_pc;
    logic               rec_btb_hit;
    logic               rec_pred_taken;
    logic [7:0]         rec_btb_index;
    logic [9:0]         rec_pht_index;
    logic [31:0]        rec_next_pc;
    logic signed [15:0] branch_offset;
    logic               is_cond_branch;
    logic               outcome_taken;
  } gbp_in_t;

  typedef struct packed {
    logic        btb_hit;
    logic        predicted_taken;
    logic [31:0] next_fetch_pc;
    logic [31:0] fall_through_pc;
    logic [7:0]  btb_index_out;
    logic [9:0]  pht_index_out;
    logic        flush;
    logic [31:0] redirect_pc;
    logic        prediction_hit;
  } gbp_out_t;

  typedef struct packed {
    logic              en;
    logic [PHT_IW-1:0] idx;
    logic [1:0]        ctr;
  } gbp_pht_wr_t;

  typedef struct packed {
    logic [31:0] addr;
    logic [31:0] target;
  } gbp_btb_entry_t;

endpackage

@@ sv/gbp_pht.sv @@
// Pattern history table: 2-bit counters in a synchronous memory, one read port,
// one write port, and a clearing pass after reset that sets every entry weakly
// not taken. Depends on gbp_pkg.
module gbp_pht (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        rd_en,
  input  logic [gbp_pkg::PHT_IW-1:0]  rd_idx,
  output logic [1:0]                  rd_ctr,
  input  gbp_pkg::gbp_pht_wr_t        wr,
  output logic                        ready
);
  import gbp_pkg::*;

  logic [1:0]        mem [PHT_ENTRIES];
  logic              clearing;
  logic [PHT_IW-1:0] clr_idx;

  assign ready = !clearing;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_idx  <= '0;
    end else if (clearing) begin
      clr_idx <= clr_idx + 1'b1;
      if (clr_idx == PHT_IW'(PHT_ENTRIES - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_idx] <= CTR_WNT;
    end else if (wr.en) begin
      mem[wr.idx] <= wr.ctr;
    end
    if (rd_en) begin
      rd_ctr <= mem[rd_idx];
    end
  end

endmodule

@@ sv/gshare_branch_predictor_btb.sv @@
// Top level: gshare direction predictor with a direct-mapped branch target buffer.
// Holds the BTB memory, valid bits, global history and the sequencer.
// Depends on gbp_pkg and gbp_pht.
//
//  channel | signals          | direction | flow control
//  --------+------------------+-----------+------------------------------------
//  request | start, req       | in        | taken when start && !busy
//  result  | done, rsp        | out       | one-cycle strobe, never held off
//
// Each word is accepted in S_IDLE, where the accept edge issues the table reads; the
// edge that ends S_EXEC raises done for one cycle and, for a resolve word, writes back
// the counter and, where due, the BTB entry and history. busy holds off a new word until S_EXEC is left.
// After reset busy stays high while all PHT_ENTRIES (1024) counters of the table are
// swept to weakly not taken. The result side cannot stall.
module gshare_branch_predictor_btb (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  gbp_pkg::gbp_in_t  req,
  output logic              done,
  output gbp_pkg::gbp_out_t rsp
);
  import gbp_pkg::*;

  typedef enum logic {S_IDLE, S_EXEC} state_t;

  state_t            state;
  gbp_in_t           req_q;
  logic [PHT_IW-1:0] hist;
  logic [PHT_IW-1:0] hist_next;
  logic              valid [BTB_ENTRIES];
  gbp_btb_entry_t    btb_mem [BTB_ENTRIES];
  gbp_btb_entry_t    btb_q;
  logic              valid_q;
  logic              pht_ready;
  logic [1:0]        pht_ctr;
  gbp_pht_wr_t       pht_wr;
  logic              accept;

  logic [BTB_IW-1:0] acc_bi;
  logic [PHT_IW-1:0] acc_pi;
  logic [BTB_IW-1:0] ex_bi;
  logic [PHT_IW-1:0] ex_pi;
  logic              btb_we;
  gbp_btb_entry_t    btb_wdata;
  gbp_out_t          rsp_next;

  assign busy   = (state == S_EXEC) || !pht_ready;
  assign accept = start && !busy;

  // table indices for a word: predict hashes the PC, resolve uses the recorded ones
  always_comb begin
    if (req.kind == KIND_PREDICT) begin
      acc_bi = req.fetch_pc[BTB_IW+1:2];
      acc_pi = req.fetch_pc[PHT_IW+1:2] ^ hist;
    end else begin
      acc_bi = req.rec_btb_index[BTB_IW-1:0];
      acc_pi = req.rec_pht_index[PHT_IW-1:0];
    end
    // history only moves at the end of an exec cycle, so this matches accept time
    if (req_q.kind == KIND_PREDICT) begin
      ex_bi = req_q.fetch_pc[BTB_IW+1:2];
      ex_pi = req_q.fetch_pc[PHT_IW+1:2] ^ hist;
    end else begin
      ex_bi = req_q.rec_btb_index[BTB_IW-1:0];
      ex_pi = req_q.rec_pht_index[PHT_IW-1:0];
    end
  end

  gbp_pht u_pht (
    .clk    (clk),
    .rst    (rst),
    .rd_en  (accept),
    .rd_idx (acc_pi),
    .rd_ctr (pht_ctr),
    .wr     (pht_wr),
    .ready  (pht_ready)
  );

  always_comb begin
    logic        hit;
    logic        taken;
    logic [31:0] fall;
    logic [31:0] stored_tgt;
    logic [31:0] alloc_tgt;
    logic [1:0]  ctr;

    rsp_next      = '0;
    btb_we        = 1'b0;
    btb_wdata     = '0;
    pht_wr        = '0;
    hist_next     = hist;
    ctr           = pht_ctr;
    fall          = req_q.fetch_pc + 32'd4;
    hit           = valid_q && (btb_q.addr == req_q.fetch_pc);
    taken         = hit && pht_ctr[1];
    // an entry never written reads back as all ones
    stored_tgt    = valid_q ? btb_q.target : '1;
    alloc_tgt     = req_q.rec_next_pc
                  + {{14{req_q.branch_offset[15]}}, req_q.branch_offset, 2'b00};

    if (req_q.kind == KIND_PREDICT) begin
      rsp_next.btb_hit         = hit;
      rsp_next.predicted_taken = taken;
      rsp_next.next_fetch_pc   = taken ? stored_tgt : fall;
      rsp_next.fall_through_pc = fall;
      rsp_next.btb_index_out   = 8'(ex_bi);
      rsp_next.pht_index_out   = 10'(ex_pi);
    end else begin
      if (req_q.rec_btb_hit) begin
        if (req_q.rec_pred_taken) begin
          if (req_q.outcome_taken) begin
            if (pht_ctr == CTR_WT) ctr = CTR_ST;
          end else begin
            if (pht_ctr[1]) ctr = pht_ctr - 2'd1;
            rsp_next.flush       = 1'b1;
            rsp_next.redirect_pc = req_q.rec_next_pc;
          end
        end else begin
          if (req_q.outcome_taken) begin
            if (!pht_ctr[1]) ctr = pht_ctr + 2'd1;
            rsp_next.flush       = 1'b1;
            rsp_next.redirect_pc = stored_tgt;
          end else begin
            if (pht_ctr == CTR_WNT) ctr = CTR_SNT;
          end
        end
      end else if (req_q.outcome_taken) begin
        // allocate on a taken branch that missed
        btb_we               = 1'b1;
        btb_wdata.addr       = req_q.rec_next_pc - 32'd4;
        btb_wdata.target     = alloc_tgt;
        ctr                  = CTR_ST;
        rsp_next.flush       = 1'b1;
        rsp_next.redirect_pc = alloc_tgt;
      end
      rsp_next.prediction_hit = !rsp_next.flush;
      pht_wr.en  = (state == S_EXEC);
      pht_wr.idx = ex_pi;
      pht_wr.ctr = ctr;
      if (req_q.is_cond_branch) begin
        hist_next = {hist[PHT_IW-2:0], req_q.outcome_taken};
      end
    end
    if (state != S_EXEC) begin
      btb_we = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
      hist  <= '0;
      for (int i = 0; i < BTB_ENTRIES; i++) begin
        valid[i] <= 1'b0;
      end
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_EXEC;
            req_q <= req;
          end
        end
        S_EXEC: begin
          state <= S_IDLE;
          done  <= 1'b1;
          rsp   <= rsp_next;
          hist  <= hist_next;
          if (btb_we) begin
            valid[ex_bi] <= 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      btb_q   <= btb_mem[acc_bi];
      valid_q <= valid[acc_bi];
    end
    if (btb_we) begin
      btb_mem[ex_bi] <= btb_wdata;
    end
  end

  function automatic logic rsp_q_kind_predict(input gbp_out_t r);
    rsp_q_kind_predict = !r.flush && !r.prediction_hit;
  endfunction

  a_accept_then_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && !done))
    else $error("accepted word did not enter exec");

  a_done_after_exec: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == S_EXEC))
    else $error("result strobe without an exec cycle");

  a_flush_vs_hit: assert property (@(posedge clk) disable iff (rst)
    done |-> (rsp.flush != rsp.prediction_hit || rsp_q_kind_predict(rsp)))
    else $error("flush and prediction_hit disagree on a resolve result");

  a_busy_while_clearing: assert property (@(posedge clk) disable iff (rst)
    !pht_ready |-> busy)
    else $error("word accepted during counter table sweep");

  a_btb_write_in_exec: assert property (@(posedge clk) disable iff (rst)
    btb_we |-> (state == S_EXEC && req_q.kind == KIND_RESOLVE && !req_q.rec_btb_hit))
    else $error("BTB written outside a resolve miss");

endmodule

@@ sim/tb.sv @@
// Self-checking bench for gshare_branch_predictor_btb: paired predict/resolve
// traffic with random gaps, checked against an in-bench gshare/BTB predictor.
// Depends on gbp_pkg and the RTL top level only.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import gbp_pkg::*;

  localparam int STALL_LIMIT = 5000;
  localparam int RANDOM_WORDS = 1200;
  localparam int POOL_N = 24;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  gbp_in_t req = '0;
  logic busy;
  logic done;
  gbp_out_t rsp;

  gshare_branch_predictor_btb DUT (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .req   (req),
    .done  (done),
    .rsp   (rsp)
  );

  always #1 clk = ~clk;

  // predictor state
  logic [PHT_IW-1:0] hist_r;
  logic [1:0]        ctr_tbl [PHT_ENTRIES];
  logic [31:0]       btb_addr [BTB_ENTRIES];
  logic [31:0]       btb_tgt [BTB_ENTRIES];
  logic              btb_vld [BTB_ENTRIES];

  gbp_in_t  words_q[$];
  gbp_out_t want_rsp[$];
  gbp_out_t fetch_log[$];

  int words_made = 0;
  int n_predict = 0;
  int n_resolve = 0;
  int n_hits = 0;
  int n_flush = 0;
  int n_results = 0;
  int mismatches = 0;
  int gap = 0;
  int idle_cycles = 0;
  logic steady = 1'b0;

  function automatic gbp_out_t gshare_eval(gbp_in_t w);
    gbp_out_t r;
    logic [BTB_IW-1:0] bi;
    logic [PHT_IW-1:0] pi;
    logic [1:0] c;
    logic [31:0] tgt;
    logic hit;
    r = '0;
    if (w.kind == KIND_PREDICT) begin
      bi = w.fetch_pc[BTB_IW+1:2];
      pi = w.fetch_pc[PHT_IW+1:2] ^ hist_r;
      hit = btb_vld[bi] && (btb_addr[bi] == w.fetch_pc);
      r.btb_hit = hit;
      r.predicted_taken = hit && (ctr_tbl[pi] >= CTR_WT);
      r.fall_through_pc = w.fetch_pc + 32'd4;
      r.next_fetch_pc = r.predicted_taken ? btb_tgt[bi] : r.fall_through_pc;
      r.btb_index_out = bi;
      r.pht_index_out = pi;
    end else begin
      bi = w.rec_btb_index[BTB_IW-1:0];
      pi = w.rec_pht_index[PHT_IW-1:0];
      c = ctr_tbl[pi];
      if (w.rec_btb_hit) begin
        if (w.rec_pred_taken) begin
          if (w.outcome_taken) begin
            if (c == CTR_WT) c = CTR_ST;
          end else begin
            if (c >= CTR_WT) c = c - 2'd1;
            r.flush = 1'b1;
            r.redirect_pc = w.rec_next_pc;
          end
        end else begin
          if (w.outcome_taken) begin
            if (c <= CTR_WNT) c = c + 2'd1;
            r.flush = 1'b1;
            r.redirect_pc = btb_tgt[bi];
          end else if (c == CTR_WNT) begin
            c = CTR_SNT;
          end
        end
      end else if (w.outcome_taken) begin
        // miss taken: allocate the entry and jump to the computed target
        tgt = w.rec_next_pc + {{14{w.branch_offset[15]}}, w.branch_offset, 2'b00};
        btb_addr[bi] = w.rec_next_pc - 32'd4;
        btb_tgt[bi] = tgt;
        btb_vld[bi] = 1'b1;
        c = CTR_ST;
        r.flush = 1'b1;
        r.redirect_pc = tgt;
      end
      ctr_tbl[pi] = c;
      if (w.is_cond_branch) hist_r = {hist_r[PHT_IW-2:0], w.outcome_taken};
      r.prediction_hit = !r.flush;
    end
    return r;
  endfunction

  function automatic gbp_in_t rand_word();
    gbp_in_t w;
    w.kind = $urandom_range(0, 1) ? KIND_RESOLVE : KIND_PREDICT;
    w.fetch_pc = $urandom;
    w.rec_btb_hit = 1'($urandom_range(0, 1));
    w.rec_pred_taken = 1'($urandom_range(0, 1));
    w.rec_btb_index = 8'($urandom_range(0, 255));
    w.rec_pht_index = 10'($urandom_range(0, 1023));
    w.rec_next_pc = $urandom;
    w.branch_offset = 16'($urandom_range(0, 65535));
    w.is_cond_branch = 1'($urandom_range(0, 1));
    w.outcome_taken = 1'($urandom_range(0, 1));
    return w;
  endfunction

  // mostly back-to-back, some short gaps, a few long ones; steady stretches have none
  function automatic int pick_gap();
    int r;
    if ($urandom_range(0, 39) == 0) steady = !steady;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic push_word(gbp_in_t w);
    words_q.push_back(w);
    words_made++;
  endtask

  task automatic predict_at(logic [31:0] pc);
    gbp_in_t w;
    w = rand_word();
    w.kind = KIND_PREDICT;
    w.fetch_pc = pc;
    push_word(w);
  endtask

  task automatic resolve_raw(logic hit, logic pred, logic [7:0] bi, logic [9:0] pi,
                             logic [31:0] npc, logic signed [15:0] off, logic cond,
                             logic taken);
    gbp_in_t w;
    w = rand_word();
    w.kind = KIND_RESOLVE;
    w.rec_btb_hit = hit;
    w.rec_pred_taken = pred;
    w.rec_btb_index = bi;
    w.rec_pht_index = pi;
    w.rec_next_pc = npc;
    w.branch_offset = off;
    w.is_cond_branch = cond;
    w.outcome_taken = taken;
    push_word(w);
  endtask

  task automatic settle();
    while (words_q.size() != 0 || want_rsp.size() != 0) @(negedge clk);
  endtask

  task automatic report(string why, gbp_out_t e, gbp_out_t g);
    mismatches++;
    if (mismatches <= 10) begin
      $display("MISMATCH %0s at %0t", why, $realtime);
      $display("  exp hit=%b tk=%b nfpc=%h ft=%h bi=%h pi=%h fl=%b rd=%h ok=%b",
               e.btb_hit, e.predicted_taken, e.next_fetch_pc, e.fall_through_pc,
               e.btb_index_out, e.pht_index_out, e.flush, e.redirect_pc, e.prediction_hit);
      $display("  got hit=%b tk=%b nfpc=%h ft=%h bi=%h pi=%h fl=%b rd=%h ok=%b",
               g.btb_hit, g.predicted_taken, g.next_fetch_pc, g.fall_through_pc,
               g.btb_index_out, g.pht_index_out, g.flush, g.redirect_pc, g.prediction_hit);
    end
  endtask

  // driver: a word is taken at an edge with start high and busy low
  always @(posedge clk) begin
    gbp_out_t e;
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        e = gshare_eval(req);
        want_rsp.push_back(e);
        if (req.kind == KIND_PREDICT) begin
          fetch_log.push_back(e);
          n_predict++;
        end else begin
          n_resolve++;
        end
        void'(words_q.pop_front());
        gap = pick_gap();
      end
      // hold the word while the block is busy
      if (!(start && busy)) begin
        if (gap > 0 || words_q.size() == 0) begin
          if (gap > 0) gap = gap - 1;
          start <= 1'b0;
          req <= rand_word();
        end else begin
          start <= 1'b1;
          req <= words_q[0];
        end
      end
    end
  end

  // monitor: every strobed result is checked against the oldest expectation
  always @(posedge clk) begin
    gbp_out_t e;
    logic bad;
    if (!rst && done) begin
      n_results++;
      if (want_rsp.size() == 0) begin
        report("result with nothing pending", '0, rsp);
      end else begin
        e = want_rsp.pop_front();
        bad = (e.btb_hit !== rsp.btb_hit) || (e.predicted_taken !== rsp.predicted_taken) ||
              (e.next_fetch_pc !== rsp.next_fetch_pc) ||
              (e.fall_through_pc !== rsp.fall_through_pc) ||
              (e.btb_index_out !== rsp.btb_index_out) ||
              (e.pht_index_out !== rsp.pht_index_out) || (e.flush !== rsp.flush) ||
              (e.redirect_pc !== rsp.redirect_pc) ||
              (e.prediction_hit !== rsp.prediction_hit);
        if (bad) report("field mismatch", e, rsp);
        if (e.btb_hit) n_hits++;
        if (e.flush) n_flush++;
      end
    end
  end

  // watchdog: give up after a long stretch with no word moving either way
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    logic [31:0] pool_pc [POOL_N];
    int pool_bias [POOL_N];
    logic pool_cond [POOL_N];
    logic signed [15:0] pool_off [POOL_N];
    int batch [$];
    int k;
    int r;
    int b;
    gbp_out_t p;

    hist_r = '0;
    for (int i = 0; i < PHT_ENTRIES; i++) ctr_tbl[i] = CTR_WNT;
    for (int i = 0; i < BTB_ENTRIES; i++) begin
      btb_addr[i] = '1;
      btb_tgt[i] = '1;
      btb_vld[i] = 1'b0;
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: address wrap, extreme offsets and indices, all four hit cases
    predict_at(32'h0000_0000);
    predict_at(32'hFFFF_FFFF);
    predict_at(32'hFFFF_FFFC);
    settle();
    resolve_raw(1'b0, 1'b0, 8'd255, 10'd1023, 32'h0000_0000, 16'sh8000, 1'b1, 1'b1);
    resolve_raw(1'b0, 1'b0, 8'd0, 10'd0, 32'h0000_0004, 16'sd32767, 1'b0, 1'b1);
    // miss with a stale taken prediction and a not-taken outcome: no BTB or counter update, only history moves
    resolve_raw(1'b0, 1'b1, 8'd7, 10'd5, 32'h0000_0100, 16'sd5, 1'b1, 1'b0);
    settle();
    predict_at(32'h0000_0000);
    predict_at(32'hFFFF_FFFC);
    settle();
    resolve_raw(1'b1, 1'b1, 8'd0, 10'd0, 32'h4, 16'sd0, 1'b1, 1'b1);
    resolve_raw(1'b1, 1'b1, 8'd0, 10'd0, 32'h4, 16'sd0, 1'b1, 1'b0);
    resolve_raw(1'b1, 1'b0, 8'd0, 10'd0, 32'h4, 16'sd0, 1'b0, 1'b1);
    // hit recorded on an entry never written: redirect to the reset target
    resolve_raw(1'b1, 1'b0, 8'd200, 10'd1, 32'h40, 16'sd0, 1'b0, 1'b1);
    resolve_raw(1'b1, 1'b0, 8'd200, 10'd2, 32'h40, 16'sd0, 1'b0, 1'b0);
    resolve_raw(1'b1, 1'b1, 8'd0, 10'd0, 32'h4, 16'sd0, 1'b0, 1'b1);
    resolve_raw(1'b1, 1'b0, 8'd0, 10'd3, 32'h4, 16'sd0, 1'b0, 1'b0);
    resolve_raw(1'b1, 1'b1, 8'd0, 10'd3, 32'h4, 16'sd0, 1'b0, 1'b0);
    settle();
    predict_at(32'h0000_0000);
    predict_at(32'hFFFF_FFFC);
    predict_at(32'hAAAA_AAA8);
    predict_at(32'h5555_5557);
    settle();

    // branch pool: mostly aligned, some aliasing on the BTB index, a few odd PCs
    for (int i = 0; i < POOL_N; i++) begin
      if (i >= 4 && $urandom_range(0, 3) == 0)
        pool_pc[i] = pool_pc[$urandom_range(0, i - 1)] ^ (32'h1 << $urandom_range(10, 31));
      else
        pool_pc[i] = $urandom & 32'hFFFF_FFFC;
      if ($urandom_range(0, 9) == 0) pool_pc[i][1:0] = 2'($urandom_range(1, 3));
      r = $urandom_range(0, 3);
      pool_bias[i] = (r == 0) ? 5 : (r == 1) ? 95 : (r == 2) ? 50 : $urandom_range(0, 100);
      pool_cond[i] = ($urandom_range(0, 4) != 0);
      pool_off[i] = 16'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                     : $urandom_range(0, 128) - 64);
    end

    words_made = 0;
    while (words_made < RANDOM_WORDS) begin
      r = $urandom_range(0, 99);
      if (r < 12) begin
        k = $urandom_range(1, 4);
        repeat (k) push_word(rand_word());
      end else begin
        // drain earlier words so the fetch log lines up with this batch
        settle();
        batch.delete();
        fetch_log.delete();
        k = $urandom_range(1, 6);
        repeat (k) begin
          b = $urandom_range(0, POOL_N - 1);
          batch.push_back(b);
          predict_at(pool_pc[b]);
        end
        settle();
        for (int i = 0; i < batch.size(); i++) begin
          p = fetch_log[i];
          b = batch[i];
          r = $urandom_range(0, 99);
          if (r < 8) continue;  // drop: branch squashed before it resolved
          if (r < 16) begin
            // stale or corrupted record
            p.predicted_taken = !p.predicted_taken;
            if ($urandom_range(0, 1)) p.pht_index_out = 10'($urandom_range(0, 1023));
          end
          resolve_raw(p.btb_hit, p.predicted_taken, p.btb_index_out, p.pht_index_out,
                      p.fall_through_pc, pool_off[b], pool_cond[b],
                      $urandom_range(1, 100) <= pool_bias[b]);
          if ($urandom_range(0, 5) == 0) predict_at($urandom);
        end
      end
    end
    settle();
    repeat (4) @(posedge clk);

    $display("covered %0d predicts and %0d resolves: %0d BTB hits, %0d flushes",
             n_predict, n_resolve, n_hits, n_flush);
    $display("%0d results checked, %0d mismatches", n_results, mismatches);
    if (mismatches == 0 && want_rsp.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
